FILE: src/lrlm_pkg.sv
package lrlm_pkg;

  // table geometry
  localparam int SEQ_ENTRIES = 256;
  localparam int SEQ_W       = 8;
  localparam int SEQ_CODES   = 1 << SEQ_W;
  localparam int IDX_W       = (SEQ_ENTRIES > 1) ? $clog2(SEQ_ENTRIES) : 1;

  // datapath widths
  localparam int CNT_W      = 32;
  localparam int AVG_W      = 40;
  localparam int PCT_W      = 15;
  localparam int AVG_SHIFT  = 8;
  localparam int DIVIDEND_W = 48;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);

  // 100 percent in q8
  localparam logic [PCT_W-1:0] PCT_Q8 = 15'd25600;

  typedef enum logic [1:0] {
    ACT_SEND_OK   = 2'd0,
    ACT_SEND_FAIL = 2'd1,
    ACT_ACK       = 2'd2,
    ACT_STATS     = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ACK,
    ST_AVG,
    ST_AVG_WAIT,
    ST_CMD,
    ST_CMD_WAIT,
    ST_TEL,
    ST_TEL_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    action_t           action;
    logic [SEQ_W-1:0]  seq;
    logic [CNT_W-1:0]  now_ms;
  } lrlm_req_t;

  typedef struct packed {
    logic              rtt_valid;
    logic [CNT_W-1:0]  rtt_ms;
    logic [AVG_W-1:0]  avg_rtt_q8;
    logic [CNT_W-1:0]  rtt_samples;
    logic [CNT_W-1:0]  attempts_total;
    logic [CNT_W-1:0]  failures_total;
    logic [CNT_W-1:0]  replies_lost;
    logic [PCT_W-1:0]  cmd_loss_pct_q8;
    logic [CNT_W-1:0]  tel_loss_pct_q8;
  } lrlm_rsp_t;

  typedef logic [IDX_W-1:0] idx_t;
  typedef idx_t idx_map_t [SEQ_CODES];

  // sequence number to table slot, folded at elaboration
  function automatic idx_map_t build_idx_map();
    idx_map_t m;
    for (int i = 0; i < SEQ_CODES; i++) begin
      m[i] = idx_t'(i % SEQ_ENTRIES);
    end
    return m;
  endfunction

  localparam idx_map_t IDX_MAP = build_idx_map();

  // x * 25600 as x * (2^14 + 2^13 + 2^10)
  function automatic logic [DIVIDEND_W-1:0] scale_pct(input logic [CNT_W-1:0] x);
    logic [DIVIDEND_W-1:0] xw;
    xw = {{(DIVIDEND_W-CNT_W){1'b0}}, x};
    return (xw << 14) + (xw << 13) + (xw << 10);
  endfunction

endpackage

FILE: src/lrlm_div.sv
module lrlm_div
  import lrlm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [CNT_W-1:0]      divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  // restoring divider, one quotient bit per cycle
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    trial;

  assign rem_sh = {rem, quotient[DIVIDEND_W-1]};
  assign trial  = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient <= dividend;
        rem      <= '0;
        dvs      <= divisor;
        steps    <= STEP_W'(DIV_STEPS);
        busy     <= 1'b1;
      end else if (busy) begin
        if (!trial[CNT_W]) begin
          rem      <= trial[CNT_W-1:0];
          quotient <= {quotient[DIVIDEND_W-2:0], 1'b1};
        end else begin
          rem      <= rem_sh[CNT_W-1:0];
          quotient <= {quotient[DIVIDEND_W-2:0], 1'b0};
        end
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/link_rtt_loss_monitor_top.sv
// Round-trip time and loss monitor for a sequence-numbered command link. Each request is one
// event (send ok, send failed, acknowledgement, stats) with a millisecond tick, and every
// request yields exactly one response. An acknowledgement whose pending bit is set waits on
// one registered read of the send-time memory, and a stats request runs three divisions
// (average rtt, command loss, reply loss) that share one restoring divider retiring one
// quotient bit per cycle over 48 steps. A division whose divisor is zero is skipped and
// reads 0. The next request is taken the cycle after the response is loaded.
// req_stall is high from acceptance until the response is loaded; the response register
// lets the next request in while an older response still waits on rsp_stall. Counters wrap
// modulo 2^32 and the pending bits clear at reset; a send-time slot is read every cycle,
// but its value is only used while its pending bit is set.
module link_rtt_loss_monitor_top
  import lrlm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  lrlm_req_t req_data,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output lrlm_rsp_t rsp_data
);

  state_t state;
  state_t state_next;

  // request being worked on
  lrlm_req_t op;
  idx_t      idx;

  // send-time memory and pending flags
  logic [CNT_W-1:0] send_time [SEQ_ENTRIES];
  logic [CNT_W-1:0] rd_time;
  logic [SEQ_ENTRIES-1:0] pending;

  // running tallies
  logic [CNT_W-1:0] rtt_total;
  logic [CNT_W-1:0] rtt_tally;
  logic [CNT_W-1:0] attempt_tally;
  logic [CNT_W-1:0] failure_tally;
  logic [CNT_W-1:0] lost_tally;

  // response under construction
  lrlm_rsp_t result;

  // shared divider hookup
  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [CNT_W-1:0]      div_divisor;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_quotient;

  logic [CNT_W-1:0] succ;
  logic [CNT_W-1:0] rtt;
  logic             rsp_free;

  assign succ     = attempt_tally - failure_tally;
  assign rtt      = op.now_ms - rd_time;
  // response register empty or draining this cycle
  assign rsp_free = !rsp_valid || !rsp_stall;

  lrlm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (op.action)
          ACT_ACK:   state_next = pending[idx] ? ST_ACK : ST_FINISH;
          ACT_STATS: state_next = ST_AVG;
          default:   state_next = ST_FINISH;
        endcase
      end
      ST_ACK:      state_next = ST_FINISH;
      ST_AVG:      state_next = (rtt_tally != '0) ? ST_AVG_WAIT : ST_CMD;
      ST_AVG_WAIT: begin
        if (div_done) state_next = ST_CMD;
      end
      ST_CMD:      state_next = (attempt_tally != '0) ? ST_CMD_WAIT : ST_TEL;
      ST_CMD_WAIT: begin
        if (div_done) state_next = ST_TEL;
      end
      ST_TEL:      state_next = (succ != '0) ? ST_TEL_WAIT : ST_FINISH;
      ST_TEL_WAIT: begin
        if (div_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (rsp_free) state_next = ST_IDLE;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and divider operands
  always_comb begin
    req_stall    = (state != ST_IDLE);
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state)
      ST_AVG: begin
        // rtt_total * 256
        div_start    = (rtt_tally != '0);
        div_dividend = {{(DIVIDEND_W-CNT_W-AVG_SHIFT){1'b0}}, rtt_total, {AVG_SHIFT{1'b0}}};
        div_divisor  = rtt_tally;
      end
      ST_CMD: begin
        div_start    = (attempt_tally != '0);
        div_dividend = scale_pct(failure_tally);
        div_divisor  = attempt_tally;
      end
      ST_TEL: begin
        div_start    = (succ != '0);
        div_dividend = scale_pct(lost_tally);
        div_divisor  = succ;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // send-time memory, registered read
  always_ff @(posedge clk) begin
    if (state == ST_EXEC && op.action == ACT_SEND_OK) begin
      send_time[idx] <= op.now_ms;
    end
    rd_time <= send_time[idx];
  end

  // control, tallies and response
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pending       <= '0;
      rtt_total     <= '0;
      rtt_tally     <= '0;
      attempt_tally <= '0;
      failure_tally <= '0;
      lost_tally    <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      state <= state_next;
      // response register: load on finish, clear once taken
      if (state == ST_FINISH && rsp_free) rsp_valid <= 1'b1;
      else if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            op     <= req_data;
            idx    <= IDX_MAP[req_data.seq];
            result <= '0;
          end
        end
        ST_EXEC: begin
          case (op.action)
            ACT_SEND_OK: begin
              attempt_tally <= attempt_tally + CNT_W'(1);
              pending[idx]  <= 1'b1;
            end
            ACT_SEND_FAIL: begin
              attempt_tally <= attempt_tally + CNT_W'(1);
              failure_tally <= failure_tally + CNT_W'(1);
            end
            ACT_STATS: begin
              // lost replies move only when successes outrun measured rtts
              if (succ > rtt_tally) lost_tally <= succ - rtt_tally;
              result.rtt_samples    <= rtt_tally;
              result.attempts_total <= attempt_tally;
              result.failures_total <= failure_tally;
            end
            default: begin
              // acknowledgement waits for the memory read
            end
          endcase
        end
        ST_ACK: begin
          rtt_total        <= rtt_total + rtt;
          rtt_tally        <= rtt_tally + CNT_W'(1);
          pending[idx]     <= 1'b0;
          result.rtt_valid <= 1'b1;
          result.rtt_ms    <= rtt;
        end
        ST_AVG_WAIT: begin
          if (div_done) result.avg_rtt_q8 <= div_quotient[AVG_W-1:0];
        end
        ST_CMD_WAIT: begin
          // above 100 percent only after wrap, clamp
          if (div_done) begin
            result.cmd_loss_pct_q8 <= (div_quotient > DIVIDEND_W'(PCT_Q8)) ?
                                      PCT_Q8 : div_quotient[PCT_W-1:0];
          end
        end
        ST_TEL: begin
          result.replies_lost <= lost_tally;
        end
        ST_TEL_WAIT: begin
          // clamp to 32 bits
          if (div_done) begin
            result.tel_loss_pct_q8 <= (|div_quotient[DIVIDEND_W-1:CNT_W]) ?
                                      {CNT_W{1'b1}} : div_quotient[CNT_W-1:0];
          end
        end
        ST_FINISH: begin
          if (rsp_free) begin
            rsp_data <= result;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: test/link_rtt_loss_monitor_top_tb.sv
module link_rtt_loss_monitor_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lrlm_pkg::*;

  // cycles with no request or response accepted before the run is declared hung
  localparam int WATCHDOG_LIMIT = 5000;
  // quiet cycles after the last response
  localparam int DRAIN_CYCLES   = 200;
  localparam int RANDOM_ITEMS   = 1880;
  localparam int IDLE_PCT       = 34;
  // sender offers back to back in this item window
  localparam int SEND_STEADY_LO = 600;
  localparam int SEND_STEADY_HI = 900;
  // sender waits for every response before this item
  localparam int SEND_PAUSE_AT  = 1200;
  // receiver never stalls in this response window
  localparam int RECV_STEADY_LO = 640;
  localparam int RECV_STEADY_HI = 940;
  // receiver holds off this long once this many responses have come
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 400;
  localparam int MAX_PRINTS     = 40;

  localparam logic [63:0] PCT_SCALE = 64'(PCT_Q8);
  localparam logic [63:0] TEL_CLAMP = 64'h0000_0000_FFFF_FFFF;

  // link statistics predictor plus the queue of responses still due
  class link_stats_board;
    logic [CNT_W-1:0] sent_tick [SEQ_ENTRIES];
    bit               awaiting_ack [SEQ_ENTRIES];
    logic [CNT_W-1:0] rtt_sum;
    logic [CNT_W-1:0] measured_count;
    logic [CNT_W-1:0] attempt_count;
    logic [CNT_W-1:0] failure_count;
    logic [CNT_W-1:0] lost_count;
    lrlm_rsp_t        due_responses [$];
    int unsigned      errors;

    function new();
      foreach (awaiting_ack[i]) begin
        awaiting_ack[i] = 1'b0;
        sent_tick[i]    = '0;
      end
      rtt_sum        = '0;
      measured_count = '0;
      attempt_count  = '0;
      failure_count  = '0;
      lost_count     = '0;
      errors         = 0;
    endfunction

    function lrlm_rsp_t apply_event(lrlm_req_t r);
      lrlm_rsp_t        o;
      int unsigned      slot;
      logic [CNT_W-1:0] delta;
      logic [CNT_W-1:0] succ;
      logic [63:0]      q;
      o    = '0;
      slot = r.seq % SEQ_ENTRIES;
      case (r.action)
        ACT_SEND_OK: begin
          attempt_count      = attempt_count + CNT_W'(1);
          sent_tick[slot]    = r.now_ms;
          awaiting_ack[slot] = 1'b1;
        end
        ACT_SEND_FAIL: begin
          attempt_count = attempt_count + CNT_W'(1);
          failure_count = failure_count + CNT_W'(1);
        end
        ACT_ACK: begin
          if (awaiting_ack[slot]) begin
            delta              = r.now_ms - sent_tick[slot];
            rtt_sum            = rtt_sum + delta;
            measured_count     = measured_count + CNT_W'(1);
            awaiting_ack[slot] = 1'b0;
            o.rtt_valid        = 1'b1;
            o.rtt_ms           = delta;
          end
        end
        default: begin
          succ = attempt_count - failure_count;
          // lost count only moves when successes outrun measured rtts
          if (succ > measured_count) lost_count = succ - measured_count;
          if (measured_count != 0) begin
            q = {24'd0, rtt_sum, 8'd0} / {32'd0, measured_count};
            o.avg_rtt_q8 = q[AVG_W-1:0];
          end
          if (attempt_count != 0) begin
            q = ({32'd0, failure_count} * PCT_SCALE) / {32'd0, attempt_count};
            if (q > PCT_SCALE) q = PCT_SCALE;
            o.cmd_loss_pct_q8 = q[PCT_W-1:0];
          end
          if (succ != 0) begin
            q = ({32'd0, lost_count} * PCT_SCALE) / {32'd0, succ};
            if (q > TEL_CLAMP) q = TEL_CLAMP;
            o.tel_loss_pct_q8 = q[CNT_W-1:0];
          end
          o.rtt_samples    = measured_count;
          o.attempts_total = attempt_count;
          o.failures_total = failure_count;
          o.replies_lost   = lost_count;
        end
      endcase
      return o;
    endfunction

    function void note_request(lrlm_req_t r);
      due_responses.push_back(apply_event(r));
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTS) $display("link monitor mismatch: %s", msg);
      errors++;
    endtask

    task check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    task check_response(lrlm_rsp_t got);
      lrlm_rsp_t want;
      if (due_responses.size() == 0) begin
        report("response with no request outstanding");
        return;
      end
      want = due_responses.pop_front();
      check_field("rtt_valid", 64'(got.rtt_valid), 64'(want.rtt_valid));
      check_field("rtt_ms", 64'(got.rtt_ms), 64'(want.rtt_ms));
      check_field("avg_rtt_q8", 64'(got.avg_rtt_q8), 64'(want.avg_rtt_q8));
      check_field("rtt_samples", 64'(got.rtt_samples), 64'(want.rtt_samples));
      check_field("attempts_total", 64'(got.attempts_total), 64'(want.attempts_total));
      check_field("failures_total", 64'(got.failures_total), 64'(want.failures_total));
      check_field("replies_lost", 64'(got.replies_lost), 64'(want.replies_lost));
      check_field("cmd_loss_pct_q8", 64'(got.cmd_loss_pct_q8), 64'(want.cmd_loss_pct_q8));
      check_field("tel_loss_pct_q8", 64'(got.tel_loss_pct_q8), 64'(want.tel_loss_pct_q8));
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  lrlm_req_t req_data  = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  lrlm_rsp_t rsp_data;

  link_stats_board tally;
  bit sender_steady  = 1'b0;
  int responses_seen = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;
  int quiet_cycles   = 0;

  link_rtt_loss_monitor_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // offer one request, idling first at random, and hold it until accepted
  task automatic drive_request(action_t act, logic [SEQ_W-1:0] seq, logic [CNT_W-1:0] tick);
    lrlm_req_t r;
    r.action = act;
    r.seq    = seq;
    r.now_ms = tick;
    while (!sender_steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    // signals read right after the edge still hold the values the block sampled
    do @(posedge clk); while (req_stall !== 1'b0);
    tally.note_request(r);
  endtask

  task automatic wait_for_all_responses();
    while (tally.due_responses.size() != 0) @(posedge clk);
  endtask

  // hand-picked events covering the corner cases of the monitor
  task automatic run_directed();
    // stats with every divisor zero
    drive_request(ACT_STATS, 8'd0, 32'd0);
    // acknowledgement with nothing pending
    drive_request(ACT_ACK, 8'd5, 32'd100);
    // send stamped at tick zero must still be measured
    drive_request(ACT_SEND_OK, 8'd0, 32'd0);
    drive_request(ACT_SEND_FAIL, 8'd255, 32'hFFFF_FFFF);
    // one success, no rtt yet: lost count goes to one
    drive_request(ACT_STATS, 8'd0, 32'd1);
    drive_request(ACT_ACK, 8'd0, 32'd7);
    // successes equal rtts: lost count keeps its old value
    drive_request(ACT_STATS, 8'd0, 32'd8);
    // repeated send on one seq overwrites the tick, ack crosses the tick wrap
    drive_request(ACT_SEND_OK, 8'd255, 32'hFFFF_FFF0);
    drive_request(ACT_SEND_OK, 8'd255, 32'hFFFF_FFFE);
    drive_request(ACT_ACK, 8'd255, 32'd3);
    // second ack on the same seq finds nothing pending
    drive_request(ACT_ACK, 8'd255, 32'd10);
    // largest possible rtt
    drive_request(ACT_SEND_OK, 8'd128, 32'h8000_0000);
    drive_request(ACT_ACK, 8'd128, 32'h7FFF_FFFF);
    drive_request(ACT_SEND_FAIL, 8'd170, 32'hAAAA_AAAA);
    drive_request(ACT_SEND_OK, 8'd85, 32'h5555_5555);
    drive_request(ACT_STATS, 8'd170, 32'h5555_5556);
    // zero rtt
    drive_request(ACT_ACK, 8'd85, 32'h5555_5555);
    drive_request(ACT_STATS, 8'd255, 32'hFFFF_FFFF);
  endtask

  // mostly send/ack pairs on a running tick, with failures, stats and noise mixed in
  task automatic run_random();
    logic [SEQ_W-1:0] sent_seqs [$];
    logic [CNT_W-1:0] tick;
    logic [SEQ_W-1:0] seq;
    action_t          act;
    int               pick;
    int               k;
    tick = $urandom();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sender_steady = (n >= SEND_STEADY_LO && n < SEND_STEADY_HI);
      if (n == SEND_PAUSE_AT) begin
        // sender goes quiet until the block has answered everything
        req_valid <= 1'b0;
        wait_for_all_responses();
        @(posedge clk);
      end
      // tick mostly creeps forward, now and then jumps anywhere
      if ($urandom_range(0, 99) < 3) tick = $urandom();
      else tick = tick + $urandom_range(0, 40);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        // noise request, every field random
        act = action_t'($urandom_range(0, 3));
        drive_request(act, SEQ_W'($urandom_range(0, 255)), $urandom());
      end else if (pick < 40) begin
        seq = SEQ_W'($urandom_range(0, 255));
        sent_seqs.push_back(seq);
        if (sent_seqs.size() > 48) void'(sent_seqs.pop_front());
        drive_request(ACT_SEND_OK, seq, tick);
      end else if (pick < 50) begin
        drive_request(ACT_SEND_FAIL, SEQ_W'($urandom_range(0, 255)), tick);
      end else if (pick < 88) begin
        // ack an outstanding send most of the time, a stray seq otherwise
        if (sent_seqs.size() != 0 && $urandom_range(0, 99) < 85) begin
          k   = $urandom_range(0, sent_seqs.size() - 1);
          seq = sent_seqs[k];
          sent_seqs.delete(k);
        end else begin
          seq = SEQ_W'($urandom_range(0, 255));
        end
        drive_request(ACT_ACK, seq, tick);
      end else begin
        drive_request(ACT_STATS, SEQ_W'($urandom_range(0, 255)), tick);
      end
    end
    sender_steady = 1'b0;
  endtask

  // response side: check what is accepted, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (rst === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      tally.check_response(rsp_data);
      responses_seen++;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (!hold_done && responses_seen >= HOLD_AT) begin
      // long hold-off so the block fills and stalls its request side
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (responses_seen >= RECV_STEADY_LO && responses_seen < RECV_STEADY_HI) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst === 1'b1 || (req_valid === 1'b1 && req_stall === 1'b0) ||
        (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("link_rtt_loss_monitor_top_tb failed");
      $finish;
    end
  end

  initial begin
    tally = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    req_valid <= 1'b0;
    wait_for_all_responses();
    // let any stray response show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tally.due_responses.size() != 0) tally.report("responses still due at end of run");
    if (tally.errors == 0) begin
      $display("link_rtt_loss_monitor_top_tb passed");
    end else begin
      $display("link_rtt_loss_monitor_top_tb failed");
    end
    $finish;
  end

endmodule
